/* rtl/sha1_message_digest_macros.svh */
// Assertion helpers for the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* rtl/sha1_pkg.sv */
// -----------------------------------------------------------------------------
// SHA-1 package
// Shared constants and the round functions used by the digest block and its core.
// -----------------------------------------------------------------------------
`default_nettype none
package sha1_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PadByte = 8'h80;

  // Round constant selected from the round number.
  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20)      k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else                k = 32'hCA62C1D6;
    return k;
  endfunction

  // Boolean function of the round.
  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20)                     f = (b & c) | (~b & d);
    else if (r >= 7'd40 && r < 7'd60)  f = (b & c) | (b & d) | (c & d);
    else                               f = b ^ c ^ d;
    return f;
  endfunction
endpackage
`default_nettype wire

/* rtl/sha1_message_digest.sv */
// SHA-1 digest of a byte stream. Bytes are taken one per transaction; the
// block is ready for the next byte at once unless a byte completes a 64-byte
// block, which then occupies the shared round unit (80 rounds plus load and
// update) while no byte is taken. The end of a message adds one or two such
// compressions plus the zero-fill, one byte at a time, and the length, then
// five digest transactions, h0 first.
// -----------------------------------------------------------------------------
// SHA-1 message digest
// Buffers message bytes, pads the final block and emits the 160-bit digest.
// -----------------------------------------------------------------------------
`default_nettype none
`include "sha1_message_digest_macros.svh"
module sha1_message_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [3:0]       m_axis_tuser,   // [2:0] word_index, [3] too_long
  output logic             m_axis_tlast    // last_word
);
  import sha1_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StComp = 3'd1;
  localparam logic [2:0] StFill = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0]   state_q;
  logic [511:0] buf_q;
  logic [32:0]  count_q;
  logic [159:0] chain_q;
  logic         final_q;     // message is in its padding phase
  logic         len_done_q;  // length block compression underway
  logic         pad_q;       // pad byte already sits in the buffer
  logic         len_blk_q;   // the length goes into the block being filled
  logic [5:0]   pos_q;
  logic [2:0]   widx_q;
  logic         too_long_q;
  logic         core_start;
  logic         core_done;
  logic [159:0] core_chain;
  logic         in_fire;
  logic         take_byte;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign take_byte = s_axis_tuser[0] && !count_q[32];

  sha1_core u_core (
    .clk_i, .rst_ni,
    .start_i(core_start), .block_i(buf_q), .chain_i(chain_q),
    .done_o(core_done), .chain_o(core_chain)
  );

  // Block buffer, byte count and sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [511:0] buf_d;
    logic         start_d;
    logic [5:0]   p;
    logic [32:0]  c;
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      chain_q <= {H0, H1, H2, H3, H4};
      final_q <= 1'b0;
      len_done_q <= 1'b0;
      pad_q <= 1'b0;
      len_blk_q <= 1'b0;
      pos_q <= '0;
      widx_q <= '0;
      too_long_q <= 1'b0;
      core_start <= 1'b0;
      buf_q <= '0;
    end else begin
      buf_d = buf_q;
      start_d = 1'b0;
      p = count_q[5:0];
      c = count_q;
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (take_byte) begin
              buf_d[511-8*p -: 8] = s_axis_tdata;
              c = count_q + 33'd1;
              count_q <= c;
            end
            too_long_q <= c[32];
            if (take_byte && p == 6'd63) begin
              final_q <= s_axis_tlast;
              pad_q <= 1'b0;
              start_d = 1'b1;
              state_q <= StComp;
            end else if (s_axis_tlast) begin
              final_q <= 1'b1;
              pad_q <= 1'b1;
              len_blk_q <= (c[5:0] < 6'd56);
              buf_d[511-8*c[5:0] -: 8] = PadByte;
              pos_q <= c[5:0] + 6'd1;
              state_q <= (c[5:0] == 6'd63) ? StComp : StFill;
              start_d = (c[5:0] == 6'd63);
            end
          end
        end
        StFill: begin
          // Zero-fill one byte a cycle; the length fills the last eight at once.
          if (len_blk_q && pos_q == 6'd56) begin
            buf_d[63:0] = {28'd0, count_q, 3'b000};
            len_done_q <= 1'b1;
            start_d = 1'b1;
            state_q <= StComp;
          end else begin
            buf_d[511-8*pos_q -: 8] = 8'h00;
            pos_q <= pos_q + 6'd1;
            if (pos_q == 6'd63) begin
              start_d = 1'b1;
              state_q <= StComp;
            end
          end
        end
        StComp: begin
          if (core_done) begin
            chain_q <= core_chain;
            if (!final_q) begin
              state_q <= StIdle;
            end else if (len_done_q) begin
              widx_q <= '0;
              state_q <= StOut;
            end else begin
              // A further padding block follows and always takes the length.
              // The pad byte opens it when the last byte filled the block.
              if (!pad_q) begin
                buf_d[511 -: 8] = PadByte;
                pos_q <= 6'd1;
                pad_q <= 1'b1;
              end else begin
                pos_q <= 6'd0;
              end
              len_blk_q <= 1'b1;
              state_q <= StFill;
            end
          end
        end
        StOut: begin
          if (m_axis_tready) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd4) begin
              state_q <= StIdle;
              chain_q <= {H0, H1, H2, H3, H4};
              count_q <= '0;
              final_q <= 1'b0;
              len_done_q <= 1'b0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
      buf_q <= buf_d;
      core_start <= start_d;
    end
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata = chain_q[159-32*widx_q -: 32];
  assign m_axis_tuser = {too_long_q, widx_q};
  assign m_axis_tlast = (widx_q == 3'd4);

  `SHA_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `SHA_ASSERT_IMP(a_idx_range, clk_i, rst_ni, m_axis_tvalid, widx_q <= 3'd4)
  `SHA_ASSERT_NXT(a_start_pulse, clk_i, rst_ni, core_start, state_q == StComp)
endmodule
`default_nettype wire

/* rtl/sha1_core.sv */
// -----------------------------------------------------------------------------
// SHA-1 compression core
// Runs 80 rounds, one per cycle, through a single shared round unit. The
// sixteen schedule words enter as a shift line and are expanded in place.
// -----------------------------------------------------------------------------
`default_nettype none
module sha1_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [511:0] block_i,
  input  wire logic [159:0] chain_i,
  output logic              done_o,
  output logic [159:0]      chain_o
);
  import sha1_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  round_q;
  logic        busy_q;
  logic        done_q;
  logic [31:0] w_new, w_cur, t;

  // Schedule: w_q[0] is the current word; new words shift in at the top.
  assign w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_cur = w_q[0];
  assign t = {a_q[26:0], a_q[31:27]} + round_f(round_q, b_q, c_q, d_q) + e_q
             + round_k(round_q) + w_cur;

  always_comb begin
    for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
    w_d[15] = {w_new[30:0], w_new[31]};
  end

  // Round datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[511-32*i -: 32];
      {a_q, b_q, c_q, d_q, e_q} <= chain_i;
    end else if (busy_q) begin
      w_q <= w_d;
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= t;
    end
  end

  // Round sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      round_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (round_q == 7'd79);
      if (start_i) begin
        busy_q <= 1'b1;
        round_q <= '0;
      end else if (busy_q) begin
        round_q <= round_q + 7'd1;
        if (round_q == 7'd79) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign chain_o = {chain_i[159:128] + a_q, chain_i[127:96] + b_q, chain_i[95:64] + c_q,
                    chain_i[63:32] + d_q, chain_i[31:0] + e_q};
endmodule
`default_nettype wire
